// ----- sv/rfbe_pkg.sv -----
// shared types, constants and helper functions for the rgb565 rect fill/blend engine
// no dependencies; imported by the scanner, the blend pipeline, the top level and the testbench
`default_nettype none

package rfbe_pkg;

    localparam int SCREEN_W_DEF = 160;
    localparam int SCREEN_H_DEF = 128;

    localparam int COORD_W = 10;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 16;
    localparam int CNT_W   = 17;

    localparam logic [CH_W-1:0] FULL_ALPHA = 8'd255;

    typedef enum logic [1:0] {
        CMD_PLOT = 2'd0,
        CMD_RECT = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    // scanner status toward the top level
    typedef struct packed {
        logic busy;
        logic pix_valid;
    } scan_stat_t;

    // blend pipeline status toward the top level
    typedef struct packed {
        logic busy;
        logic wr_en;
    } blend_stat_t;

    function automatic logic [PIX_W-1:0] pack565(input logic [CH_W-1:0] r,
                                                 input logic [CH_W-1:0] g,
                                                 input logic [CH_W-1:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // exact floor(s / 255) for s below 16320
    function automatic logic [5:0] div255(input logic [13:0] s);
        logic [15:0] t;
        t = {2'b00, s} + {10'd0, s[13:8]} + 16'd1;
        return t[13:8];
    endfunction

endpackage

`default_nettype wire

// ----- sv/rfbe_frame_mem.sv -----
// frame memory: one write port, one read port with registered read data
// depends on nothing but its parameters
`default_nettype none

module rfbe_frame_mem #(
    parameter int DEPTH = 20480,
    parameter int AW    = 15,
    parameter int DW    = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/rfbe_scan.sv -----
// pixel position scanner: walks a clipped rectangle one position per cycle
// depends on rfbe_pkg
`default_nettype none

module rfbe_scan #(
    parameter int SCREEN_W = 160,
    parameter int SCREEN_H = 128,
    parameter int XW       = 8,
    parameter int YW       = 7,
    parameter int AW       = 15
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [rfbe_pkg::COORD_W-1:0] x,
    input  wire logic [rfbe_pkg::COORD_W-1:0] y,
    input  wire logic [rfbe_pkg::COORD_W-1:0] rect_width,
    input  wire logic [rfbe_pkg::COORD_W-1:0] rect_height,
    input  wire logic                        fill,
    output rfbe_pkg::scan_stat_t             stat,
    output logic [AW-1:0]                    addr
);

    import rfbe_pkg::*;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_SETUP,
        SC_RUN
    } scan_state_t;

    localparam logic [AW-1:0]      W_A    = AW'(SCREEN_W);
    localparam logic [XW-1:0]      XMAX   = XW'(SCREEN_W - 1);
    localparam logic [YW-1:0]      YMAX   = YW'(SCREEN_H - 1);
    localparam logic [COORD_W:0]   XMAX_E = (COORD_W + 1)'(SCREEN_W - 1);
    localparam logic [COORD_W:0]   YMAX_E = (COORD_W + 1)'(SCREEN_H - 1);
    localparam logic [COORD_W-1:0] W_C    = COORD_W'(SCREEN_W);
    localparam logic [COORD_W-1:0] H_C    = COORD_W'(SCREEN_H);

    scan_state_t        state_reg;
    logic [COORD_W-1:0] x0_reg, y0_reg;
    logic [XW-1:0]      xm_reg, x0n_reg, cx_reg;
    logic [YW-1:0]      ym_reg, y0n_reg, cy_reg;
    logic               fill_reg, off_reg;
    logic [AW-1:0]      row_reg, addr_reg;

    logic [COORD_W:0]   x_end, y_end;
    logic [XW-1:0]      xm_next;
    logic [YW-1:0]      ym_next;
    logic [YW-1:0]      y0n;
    logic [AW-1:0]      base_row;
    logic               on_edge;

    always_comb
    begin
        x_end   = {1'b0, x} + {1'b0, rect_width} - (COORD_W + 1)'(1);
        y_end   = {1'b0, y} + {1'b0, rect_height} - (COORD_W + 1)'(1);
        xm_next = (x_end > XMAX_E) ? XMAX : x_end[XW-1:0];
        ym_next = (y_end > YMAX_E) ? YMAX : y_end[YW-1:0];
        y0n     = y0_reg[YW-1:0];
        base_row = AW'(y0n) * W_A;
        on_edge = (cy_reg == y0n_reg) || (cy_reg == ym_reg) ||
                  (cx_reg == x0n_reg) || (cx_reg == xm_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
        end
        else
        begin
            case (state_reg)
                SC_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= SC_SETUP;
                    end
                end
                SC_SETUP:
                begin
                    state_reg <= off_reg ? SC_IDLE : SC_RUN;
                end
                SC_RUN:
                begin
                    if ((cx_reg == xm_reg) && (cy_reg == ym_reg))
                    begin
                        state_reg <= SC_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= SC_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    x0_reg   <= x;
                    y0_reg   <= y;
                    xm_reg   <= xm_next;
                    ym_reg   <= ym_next;
                    fill_reg <= fill;
                    off_reg  <= (x >= W_C) || (y >= H_C);
                end
            end
            SC_SETUP:
            begin
                x0n_reg  <= x0_reg[XW-1:0];
                y0n_reg  <= y0n;
                cx_reg   <= x0_reg[XW-1:0];
                cy_reg   <= y0n;
                row_reg  <= base_row;
                addr_reg <= base_row + AW'(x0_reg[XW-1:0]);
            end
            SC_RUN:
            begin
                if (cx_reg == xm_reg)
                begin
                    // next row starts back at the left edge
                    cx_reg   <= x0n_reg;
                    cy_reg   <= cy_reg + YW'(1);
                    row_reg  <= row_reg + W_A;
                    addr_reg <= row_reg + W_A + AW'(x0n_reg);
                end
                else
                begin
                    cx_reg   <= cx_reg + XW'(1);
                    addr_reg <= addr_reg + AW'(1);
                end
            end
            default:
            begin
                off_reg <= 1'b1;
            end
        endcase
    end

    assign stat.busy      = (state_reg != SC_IDLE);
    assign stat.pix_valid = (state_reg == SC_RUN) && (fill_reg || on_edge);
    assign addr           = addr_reg;

endmodule

`default_nettype wire

// ----- sv/rfbe_blend.sv -----
// three-stage alpha blend pipeline: products, sums, divide by 255 and write
// depends on rfbe_pkg
`default_nettype none

module rfbe_blend #(
    parameter int AW = 15
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [AW-1:0]             in_addr,
    input  wire logic [rfbe_pkg::PIX_W-1:0] old_pix,
    input  wire logic [rfbe_pkg::PIX_W-1:0] colour,
    input  wire logic [rfbe_pkg::CH_W-1:0]  alpha,
    output rfbe_pkg::blend_stat_t          stat,
    output logic [AW-1:0]                  wr_addr,
    output logic [rfbe_pkg::PIX_W-1:0]     wr_data
);

    import rfbe_pkg::*;

    logic [CH_W-1:0] inv;

    logic             v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]    addr1_reg, addr2_reg, addr3_reg;
    logic             full1_reg, full2_reg;
    logic [PIX_W-1:0] col1_reg, col2_reg, data3_reg;
    logic [12:0]      po_r_reg, pn_r_reg, po_b_reg, pn_b_reg;
    logic [13:0]      po_g_reg, pn_g_reg;
    logic [12:0]      s_r_reg, s_b_reg;
    logic [13:0]      s_g_reg;

    // quotients of the sums by 255
    logic [4:0]       q_r, q_b;
    logic [5:0]       q_g;

    assign inv = FULL_ALPHA - alpha;

    assign q_r = 5'(div255({1'b0, s_r_reg}));
    assign q_g = div255(s_g_reg);
    assign q_b = 5'(div255({1'b0, s_b_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        addr1_reg <= in_addr;
        full1_reg <= (alpha == FULL_ALPHA);
        col1_reg  <= colour;
        po_r_reg  <= 13'(inv) * 13'(old_pix[15:11]);
        pn_r_reg  <= 13'(alpha) * 13'(colour[15:11]);
        po_g_reg  <= 14'(inv) * 14'(old_pix[10:5]);
        pn_g_reg  <= 14'(alpha) * 14'(colour[10:5]);
        po_b_reg  <= 13'(inv) * 13'(old_pix[4:0]);
        pn_b_reg  <= 13'(alpha) * 13'(colour[4:0]);

        addr2_reg <= addr1_reg;
        full2_reg <= full1_reg;
        col2_reg  <= col1_reg;
        s_r_reg   <= po_r_reg + pn_r_reg;
        s_g_reg   <= po_g_reg + pn_g_reg;
        s_b_reg   <= po_b_reg + pn_b_reg;

        addr3_reg <= addr2_reg;
        if (full2_reg)
        begin
            data3_reg <= col2_reg;
        end
        else
        begin
            data3_reg <= {q_r, q_g, q_b};
        end
    end

    assign stat.busy  = v1_reg || v2_reg || v3_reg;
    assign stat.wr_en = v3_reg;
    assign wr_addr    = addr3_reg;
    assign wr_data    = data3_reg;

endmodule

`default_nettype wire

// ----- sv/rgb565_rect_fill_blend_engine_core.sv -----
// top level of the rgb565 rect fill/blend engine: command control, clear pass, result word
// depends on rfbe_pkg, rfbe_frame_mem, rfbe_scan, rfbe_blend
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    s_tdata: command fields, s_tuser: command code
//  m_*       out  m_tvalid/m_tready    m_tdata: read_data, pixels_written
//  enable_*  in   enable_we            enable_wdata: rectangle enable register
//
//  after reset the frame memory is cleared to black, one entry a cycle, through all
//  SCREEN_W*SCREEN_H entries (20480 by default); no command word is taken meanwhile
//  one command at a time: a plot, a read or an enabled rectangle of nonzero size runs
//  through the scanner, which steps one pixel position a cycle through the frame
//  memory read port over the clipped area, then the blend pipeline drains
//  the result sits in an output register, so a new command word is taken while it
//  waits; a finished command stalls only if the previous result is still unread
`default_nettype none

module rgb565_rect_fill_blend_engine_core #(
    parameter int SCREEN_W = rfbe_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = rfbe_pkg::SCREEN_H_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata, from bit 0: x[10], y[10], rect_width[10], rect_height[10], fill[1],
    // red[8], green[8], blue[8], alpha[8], zero pad[7]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,
    // s_tuser, from bit 0: command[2]
    input  wire logic [1:0]  s_tuser,
    // m_tdata, from bit 0: read_data[16], pixels_written[17], zero pad[7]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,
    input  wire logic        enable_we,
    input  wire logic        enable_wdata
);

    import rfbe_pkg::*;

    localparam int DEPTH = SCREEN_W * SCREEN_H;
    localparam int XW    = (SCREEN_W > 1) ? $clog2(SCREEN_W) : 1;
    localparam int YW    = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    // input word fields
    logic [COORD_W-1:0] in_x, in_y, in_w, in_h;
    logic               in_fill;
    logic [CH_W-1:0]    in_r, in_g, in_b, in_a;
    cmd_t               in_cmd;

    logic accept, needs_scan, scan_start, load_out;

    logic [AW-1:0]    clr_cnt_reg;
    logic             enable_reg;
    cmd_t             cmd_reg;
    logic [PIX_W-1:0] colour_reg;
    logic [CH_W-1:0]  alpha_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PIX_W-1:0] rdata_hold_reg;
    logic             pix_d1_valid_reg;
    logic [AW-1:0]    pix_d1_addr_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_read_reg;
    logic [CNT_W-1:0] out_count_reg;

    scan_stat_t       scan_stat;
    logic [AW-1:0]    scan_addr;
    blend_stat_t      blend_stat;
    logic [AW-1:0]    blend_addr;
    logic [PIX_W-1:0] blend_data;
    logic [PIX_W-1:0] mem_rdata;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [PIX_W-1:0] mem_wdata;

    assign in_x    = s_tdata[9:0];
    assign in_y    = s_tdata[19:10];
    assign in_w    = s_tdata[29:20];
    assign in_h    = s_tdata[39:30];
    assign in_fill = s_tdata[40];
    assign in_r    = s_tdata[48:41];
    assign in_g    = s_tdata[56:49];
    assign in_b    = s_tdata[64:57];
    assign in_a    = s_tdata[72:65];
    assign in_cmd  = cmd_t'(s_tuser);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // plot and read go through the scanner as a filled one-pixel rectangle;
    // a rectangle runs only when enabled and of nonzero size
    always_comb
    begin
        case (in_cmd)
            CMD_PLOT: needs_scan = 1'b1;
            CMD_READ: needs_scan = 1'b1;
            CMD_RECT: needs_scan = enable_reg && (in_w != '0) && (in_h != '0);
            default:  needs_scan = 1'b0;
        endcase
    end

    assign scan_start = accept && needs_scan;
    assign load_out   = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = needs_scan ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (!scan_stat.busy)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last blended pixel must have reached the memory
                if (!pix_d1_valid_reg && !blend_stat.busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            enable_reg       <= 1'b0;
            pix_d1_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pix_d1_valid_reg <= scan_stat.pix_valid;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (enable_we)
            begin
                enable_reg <= enable_wdata;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // per-command payload, pixel count and read capture
    always_ff @(posedge clk)
    begin
        pix_d1_addr_reg <= scan_addr;
        if (accept)
        begin
            cmd_reg        <= in_cmd;
            colour_reg     <= pack565(in_r, in_g, in_b);
            alpha_reg      <= in_a;
            count_reg      <= '0;
            rdata_hold_reg <= '0;
        end
        else
        begin
            if (scan_stat.pix_valid && (cmd_reg != CMD_READ))
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (pix_d1_valid_reg && (cmd_reg == CMD_READ))
            begin
                rdata_hold_reg <= mem_rdata;
            end
        end
        if (load_out)
        begin
            out_read_reg  <= rdata_hold_reg;
            out_count_reg <= count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_count_reg, out_read_reg};

    // clear pass owns the write port until it finishes
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = blend_stat.wr_en;
            mem_waddr = blend_addr;
            mem_wdata = blend_data;
        end
    end

    rfbe_scan #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H),
        .XW       (XW),
        .YW       (YW),
        .AW       (AW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (scan_start),
        .x           (in_x),
        .y           (in_y),
        .rect_width  ((in_cmd == CMD_RECT) ? in_w : COORD_W'(1)),
        .rect_height ((in_cmd == CMD_RECT) ? in_h : COORD_W'(1)),
        .fill        ((in_cmd == CMD_RECT) ? in_fill : 1'b1),
        .stat        (scan_stat),
        .addr        (scan_addr)
    );

    rfbe_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (PIX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (scan_stat.pix_valid),
        .raddr (scan_addr),
        .rdata (mem_rdata)
    );

    // pixels within one command never repeat, so no forwarding is needed
    rfbe_blend #(
        .AW (AW)
    ) u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix_d1_valid_reg && (cmd_reg != CMD_READ)),
        .in_addr  (pix_d1_addr_reg),
        .old_pix  (mem_rdata),
        .colour   (colour_reg),
        .alpha    (alpha_reg),
        .stat     (blend_stat),
        .wr_addr  (blend_addr),
        .wr_data  (blend_data)
    );

endmodule

`default_nettype wire

// ----- sv/rfbe_checker.sv -----
// port-level assertions for the rgb565 rect fill/blend engine, bound to the top level
// depends on rgb565_rect_fill_blend_engine_core
`default_nettype none

module rfbe_checker #(
    parameter int SCREEN_W = 160,
    parameter int SCREEN_H = 128
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    localparam logic [16:0] MAX_PIX = 17'(SCREEN_W * SCREEN_H);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one command in flight: no word taken right after one was taken
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command word taken while one is in flight");

    // a result with nonzero read data never reports written pixels
    a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[15:0] != 16'd0) |-> (m_tdata[32:16] == 17'd0))
        else $error("nonzero read data with nonzero pixel count");

    // never more pixels than the screen holds
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[32:16] <= MAX_PIX))
        else $error("pixel count exceeds screen size");

endmodule

bind rgb565_rect_fill_blend_engine_core rfbe_checker #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
) u_rfbe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata)
);

`default_nettype wire

// ----- tb/rgb565_rect_fill_blend_engine_core_test.sv -----
// self-checking testbench for the rgb565 rect fill/blend engine: plot, read, rectangles, blending
// depends on rfbe_pkg and rgb565_rect_fill_blend_engine_core; keeps its own shadow frame buffer
`default_nettype none

module rgb565_rect_fill_blend_engine_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rfbe_pkg::*;

    localparam int SCREEN_W     = SCREEN_W_DEF;
    localparam int SCREEN_H     = SCREEN_H_DEF;
    localparam int IDLE_PCT     = 12;
    // cycles to let the pipeline drain once the last result word is in
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_WORDS = 76;
    localparam int PHASES       = 4;

    // one command word as the sender sees it
    typedef struct packed {
        cmd_t             op;
        logic [9:0]       x;
        logic [9:0]       y;
        logic [9:0]       w;
        logic [9:0]       h;
        logic             fill;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  alpha;
    } draw_cmd_t;

    // one result word: read pixel and count of pixels written
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [CNT_W-1:0] count;
    } draw_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        enable_we = 1'b0;
    logic        enable_wdata = 1'b0;

    // shadow copy of the frame memory and of the rectangle enable register
    logic [PIX_W-1:0] shadow_fb [SCREEN_W*SCREEN_H];
    logic             rect_enable;
    draw_result_t     expected_results [$];
    int unsigned      mismatch_count;
    // when set, neither side inserts idle cycles
    bit               steady;

    rgb565_rect_fill_blend_engine_core #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .enable_we    (enable_we),
        .enable_wdata (enable_wdata)
    );

    always #5 clk = ~clk;

    // watchdog, far beyond the slowest legal run of this stimulus
    initial
    begin
        #100_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    // per-channel blend, truncating division by full opacity
    function automatic int unsigned blend_channel(int unsigned old_c, int unsigned new_c,
                                                  int unsigned a);
        return ((255 - a) * old_c + a * new_c) / 255;
    endfunction

    // writes one pixel of the shadow buffer; returns 1 when it lands on screen
    function automatic int unsigned shadow_plot(int unsigned px, int unsigned py,
                                                logic [PIX_W-1:0] colour,
                                                logic [CH_W-1:0] a);
        int unsigned      idx;
        logic [PIX_W-1:0] old;
        logic [4:0]       r;
        logic [5:0]       g;
        logic [4:0]       b;
        if (px >= SCREEN_W || py >= SCREEN_H)
            return 0;
        idx = py * SCREEN_W + px;
        if (a < FULL_ALPHA)
        begin
            old = shadow_fb[idx];
            r = 5'(blend_channel(32'(old[15:11]), 32'(colour[15:11]), 32'(a)));
            g = 6'(blend_channel(32'(old[10:5]), 32'(colour[10:5]), 32'(a)));
            b = 5'(blend_channel(32'(old[4:0]), 32'(colour[4:0]), 32'(a)));
            shadow_fb[idx] = {r, g, b};
        end
        else
        begin
            shadow_fb[idx] = colour;
        end
        return 1;
    endfunction

    // applies one command to the shadow buffer and returns the result word it should give
    function automatic draw_result_t apply_draw_cmd(draw_cmd_t c);
        draw_result_t     res;
        logic [PIX_W-1:0] colour;
        int unsigned      x_end;
        int unsigned      y_end;
        int unsigned      cx;
        int unsigned      cy;
        res = '0;
        colour = {c.red[7:3], c.green[7:2], c.blue[7:3]};
        case (c.op)
            CMD_PLOT:
                res.count = CNT_W'(shadow_plot(32'(c.x), 32'(c.y), colour, c.alpha));
            CMD_RECT:
                if (rect_enable && c.w != 0 && c.h != 0)
                begin
                    // right and bottom edges clip to the screen and then count as outline
                    x_end = c.x + c.w - 1;
                    y_end = c.y + c.h - 1;
                    if (x_end > SCREEN_W - 1)
                        x_end = SCREEN_W - 1;
                    if (y_end > SCREEN_H - 1)
                        y_end = SCREEN_H - 1;
                    for (cy = c.y; cy <= y_end; cy++)
                        for (cx = c.x; cx <= x_end; cx++)
                            if (c.fill || cy == c.y || cy == y_end || cx == c.x || cx == x_end)
                                res.count = res.count +
                                            CNT_W'(shadow_plot(cx, cy, colour, c.alpha));
                end
            CMD_READ:
                if (c.x < SCREEN_W && c.y < SCREEN_H)
                    res.pixel = shadow_fb[c.y * SCREEN_W + c.x];
            default:
                res = '0;
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(string what);
        mismatch_count++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // receiver stalls at random unless the steady stretch is on
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin : check_results
        draw_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                flag_mismatch($sformatf("result word %h with nothing pending", m_tdata));
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[15:0] !== want.pixel)
                    flag_mismatch($sformatf("read_data %h, expected %h",
                                            m_tdata[15:0], want.pixel));
                if (m_tdata[32:16] !== want.count)
                    flag_mismatch($sformatf("pixels_written %0d, expected %0d",
                                            m_tdata[32:16], want.count));
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic draw_cmd_t make_cmd(cmd_t op, int x, int y, int w, int h, bit fill,
                                           int r, int g, int b, int a);
        draw_cmd_t c;
        c.op = op;
        c.x = 10'(x);
        c.y = 10'(y);
        c.w = 10'(w);
        c.h = 10'(h);
        c.fill = fill;
        c.red = 8'(r);
        c.green = 8'(g);
        c.blue = 8'(b);
        c.alpha = 8'(a);
        return c;
    endfunction

    // sends one command word; valid stays high after the handshake so back-to-back
    // words never lower and raise it in the same step
    task automatic send_cmd(draw_cmd_t c);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.op;
        s_tdata  <= {7'd0, c.alpha, c.blue, c.green, c.red, c.fill, c.h, c.w, c.y, c.x};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(apply_draw_cmd(c));
    endtask

    // stops sending and waits until every pending result word is in and the block is quiet
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_rect_enable(logic on);
        settle_block();
        enable_we    <= 1'b1;
        enable_wdata <= on;
        @(posedge clk);
        enable_we   <= 1'b0;
        rect_enable = on;
    endtask

    function automatic draw_cmd_t random_cmd();
        draw_cmd_t   c;
        int unsigned pick;
        pick = $urandom_range(99);
        c.op = pick < 35 ? CMD_PLOT : pick < 65 ? CMD_RECT : pick < 95 ? CMD_READ : CMD_NOP;
        // mostly on screen, now and then anywhere in the 10-bit range
        if ($urandom_range(9) == 0)
        begin
            c.x = 10'($urandom_range(1023));
            c.y = 10'($urandom_range(1023));
        end
        else
        begin
            c.x = 10'($urandom_range(SCREEN_W - 1));
            c.y = 10'($urandom_range(SCREEN_H - 1));
        end
        pick = $urandom_range(99);
        if (c.op != CMD_RECT)
        begin
            c.w = 10'($urandom_range(1023));
            c.h = 10'($urandom_range(1023));
        end
        else if (pick < 80)
        begin
            // small rectangles keep the run short
            c.w = 10'($urandom_range(12));
            c.h = 10'($urandom_range(12));
        end
        else if (pick < 95)
        begin
            // any size, anchored near the corner so clipping keeps it small
            c.w = 10'($urandom_range(1023));
            c.h = 10'($urandom_range(1023));
            c.x = 10'($urandom_range(SCREEN_W - 1, SCREEN_W - 20));
            c.y = 10'($urandom_range(SCREEN_H - 1, SCREEN_H - 20));
        end
        else
        begin
            c.w = 10'($urandom_range(1023));
            c.h = 10'($urandom_range(1023));
        end
        c.fill  = 1'($urandom_range(1));
        c.red   = 8'($urandom_range(255));
        c.green = 8'($urandom_range(255));
        c.blue  = 8'($urandom_range(255));
        c.alpha = ($urandom_range(99) < 40) ? 8'd255 : 8'($urandom_range(255));
        return c;
    endfunction

    // ---------------------------------------------------------------- tests

    // plots and reads work with the rectangle enable still at its reset value
    task automatic test_pixel_access();
        send_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_PLOT, 0, 0, 0, 0, 0, 255, 255, 255, 255));
        send_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_PLOT, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 0, 255, 0, 0, 255));
        send_cmd(make_cmd(CMD_READ, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 0, 0, 0, 0, 0));
        // off-screen plots and reads
        send_cmd(make_cmd(CMD_PLOT, SCREEN_W, 0, 0, 0, 0, 255, 255, 255, 255));
        send_cmd(make_cmd(CMD_PLOT, 1023, 1023, 1023, 1023, 1, 255, 255, 255, 255));
        send_cmd(make_cmd(CMD_READ, 1023, 5, 0, 0, 0, 0, 0, 0, 0));
        // half-opaque black over white, then fully transparent
        send_cmd(make_cmd(CMD_PLOT, 0, 0, 0, 0, 0, 0, 0, 0, 128));
        send_cmd(make_cmd(CMD_PLOT, 0, 0, 0, 0, 0, 0, 255, 0, 0));
        send_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // unused command code with every field bit set
        send_cmd(make_cmd(CMD_NOP, 1023, 1023, 1023, 1023, 1, 255, 255, 255, 255));
    endtask

    task automatic test_rect_gating();
        send_cmd(make_cmd(CMD_RECT, 10, 10, 10, 10, 1, 255, 255, 255, 255));
        set_rect_enable(1'b1);
        send_cmd(make_cmd(CMD_RECT, 10, 10, 3, 3, 1, 0, 255, 0, 255));
        set_rect_enable(1'b0);
        send_cmd(make_cmd(CMD_RECT, 10, 10, 3, 3, 1, 0, 0, 255, 255));
        set_rect_enable(1'b1);
    endtask

    task automatic test_rect_shapes();
        // zero width and zero height
        send_cmd(make_cmd(CMD_RECT, 5, 5, 0, 7, 1, 255, 255, 255, 255));
        send_cmd(make_cmd(CMD_RECT, 5, 5, 7, 0, 1, 255, 255, 255, 255));
        send_cmd(make_cmd(CMD_RECT, 2, 2, 4, 3, 1, 255, 0, 0, 255));
        send_cmd(make_cmd(CMD_RECT, 20, 20, 5, 5, 0, 0, 0, 255, 255));
        // clipped outline: the cut edges count as outline
        send_cmd(make_cmd(CMD_RECT, 150, 120, 1023, 1023, 0, 255, 255, 0, 255));
        send_cmd(make_cmd(CMD_RECT, 155, 125, 20, 20, 1, 0, 255, 255, 77));
        // corner off screen
        send_cmd(make_cmd(CMD_RECT, SCREEN_W, 10, 4, 4, 1, 255, 255, 255, 255));
        // whole screen, then a faint whole-screen outline blended over it
        send_cmd(make_cmd(CMD_RECT, 0, 0, SCREEN_W, SCREEN_H, 1, 0, 255, 0, 255));
        send_cmd(make_cmd(CMD_RECT, 0, 0, 1023, 1023, 0, 255, 0, 255, 1));
        send_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_READ, 80, 64, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(CMD_READ, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // random traffic in phases; the enable is rewritten at random after each phase, one phase runs steady
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned n;
        for (phase = 0; phase < PHASES; phase++)
        begin
            steady = (phase == 1);
            for (n = 0; n < RANDOM_WORDS / PHASES; n++)
                send_cmd(random_cmd());
            steady = 1'b0;
            set_rect_enable($urandom_range(3) != 0);
        end
    endtask

    initial
    begin
        mismatch_count = 0;
        rect_enable = 1'b0;
        steady = 1'b0;
        // frame memory comes up black
        foreach (shadow_fb[i])
            shadow_fb[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_pixel_access();
        test_rect_gating();
        test_rect_shapes();
        test_random_traffic();

        settle_block();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/rfbe_pkg.sv
sv/rfbe_frame_mem.sv
sv/rfbe_scan.sv
sv/rfbe_blend.sv
sv/rgb565_rect_fill_blend_engine_core.sv
sv/rfbe_checker.sv
tb/rgb565_rect_fill_blend_engine_core_test.sv
